>>> rtl/swrl_pkg.sv
// Shared types and constants of the sliding window rate limiter.
// Field widths, configuration register indexes, controller command/status.
// No dependencies.
`default_nettype none

package swrl_pkg;

  localparam int ID_W         = 64;
  localparam int RATE_W       = 5;
  localparam int WIN_W        = 16;
  localparam int WAIT_W       = 17;
  localparam int PEND_CNT_W   = 7;
  localparam int FLIGHT_CNT_W = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS = 2'd1;

  localparam logic [RATE_W-1:0] MAX_RATE_RST     = 5'd16;
  localparam logic [WIN_W-1:0]  WINDOW_TICKS_RST = 16'd1000;

  localparam logic ACTION_TICK = 1'b1;

  typedef struct packed {
    logic ingest;
    logic pop;
    logic capture;
    logic plan;
    logic release_id;
    logic empty_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic expire;
    logic plan_release;
    logic last_release;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> rtl/swrl_ctrl.sv
// Controller state machine of the rate limiter.
// Sequences ingest, expiry, planning and release of items; uses swrl_pkg.
`default_nettype none

module swrl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire swrl_pkg::ctrl_sts_t  sts,
  output swrl_pkg::ctrl_cmd_t       cmd
);
  import swrl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXPIRE = 6'b000010,
    S_PLAN   = 6'b000100,
    S_READ   = 6'b001000,
    S_LOAD   = 6'b010000,
    S_NONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ingest = 1'b1;
          state_next = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        if (sts.expire) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.capture = 1'b1;
          state_next  = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = sts.plan_release ? S_READ : S_NONE;
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.release_id = 1'b1;
          state_next     = sts.last_release ? S_IDLE : S_READ;
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.empty_result = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/swrl_dp.sv
// Datapath of the rate limiter: time counter, release log, pending id queue,
// configuration registers and output register. Uses swrl_pkg.
`default_nettype none

module swrl_dp #(
  parameter int MAX_IN_FLIGHT = 16,
  parameter int QUEUE_DEPTH   = 64,
  parameter int TIME_WIDTH    = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_action,
  input  wire logic [swrl_pkg::ID_W-1:0]           in_id,
  input  wire logic                                cfg_we,
  input  wire logic [swrl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire swrl_pkg::ctrl_cmd_t                 cmd,
  output swrl_pkg::ctrl_sts_t                      sts,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_has_release,
  output logic [swrl_pkg::ID_W-1:0]                out_id,
  output logic                                     out_last,
  output logic [swrl_pkg::PEND_CNT_W-1:0]          out_pending,
  output logic [swrl_pkg::FLIGHT_CNT_W-1:0]        out_in_flight,
  output logic [swrl_pkg::WAIT_W-1:0]              out_wait,
  output logic                                     out_dropped
);
  import swrl_pkg::*;

  localparam int LOG_IW = (MAX_IN_FLIGHT > 1) ? $clog2(MAX_IN_FLIGHT) : 1;
  localparam int CNT_W  = $clog2(MAX_IN_FLIGHT + 1);
  localparam int Q_IW   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W  = (CNT_W > RATE_W) ? CNT_W : RATE_W;
  localparam int NW     = (FILL_W > LIM_W) ? FILL_W : LIM_W;

  localparam logic [LOG_IW-1:0] LOG_LAST = LOG_IW'(MAX_IN_FLIGHT - 1);
  localparam logic [Q_IW-1:0]   Q_LAST   = Q_IW'(QUEUE_DEPTH - 1);

  logic [RATE_W-1:0]     max_rate;
  logic [WIN_W-1:0]      window_ticks;
  logic [TIME_WIDTH-1:0] now_ticks;
  logic [TIME_WIDTH-1:0] log_mem [MAX_IN_FLIGHT];
  logic [LOG_IW-1:0]     log_head;
  logic [CNT_W-1:0]      log_count;
  logic [ID_W-1:0]       q_mem [QUEUE_DEPTH];
  logic [Q_IW-1:0]       q_head;
  logic [FILL_W-1:0]     q_fill;
  logic [ID_W-1:0]       rd_id;
  logic                  drop_flag;
  logic [WIN_W-1:0]      head_age;
  logic [CNT_W-1:0]      rel_left;
  logic [FILL_W-1:0]     fin_pending;
  logic [CNT_W-1:0]      fin_count;
  logic [WAIT_W-1:0]     fin_wait;

  logic [TIME_WIDTH-1:0] age;
  logic                  expire;
  logic [LIM_W-1:0]      limit, room;
  logic [NW-1:0]         nrel_w;
  logic [CNT_W-1:0]      nrel;
  logic [FILL_W-1:0]     pend_after;
  logic [CNT_W-1:0]      count_after;
  logic [WAIT_W-1:0]     wait_value;
  logic [CNT_W:0]        log_tail_sum;
  logic [LOG_IW-1:0]     log_tail;
  logic [FILL_W:0]       q_tail_sum;
  logic [Q_IW-1:0]       q_tail;
  logic                  q_full;
  logic                  out_free;

  assign age    = now_ticks - log_mem[log_head];
  assign expire = (log_count != '0) && (age > TIME_WIDTH'(window_ticks));

  assign limit  = (LIM_W'(max_rate) > LIM_W'(MAX_IN_FLIGHT)) ?
                  LIM_W'(MAX_IN_FLIGHT) : LIM_W'(max_rate);
  assign room   = (limit > LIM_W'(log_count)) ? (limit - LIM_W'(log_count)) : '0;
  assign nrel_w = (NW'(q_fill) < NW'(room)) ? NW'(q_fill) : NW'(room);
  assign nrel   = CNT_W'(nrel_w);

  assign pend_after  = q_fill - FILL_W'(nrel);
  assign count_after = log_count + nrel;
  assign wait_value  = ((pend_after != '0) && (count_after != '0)) ?
                       (WAIT_W'(window_ticks) + WAIT_W'(1) - WAIT_W'(head_age)) : '0;

  assign log_tail_sum = (CNT_W+1)'(log_head) + (CNT_W+1)'(log_count);
  assign log_tail     = (log_tail_sum >= (CNT_W+1)'(MAX_IN_FLIGHT)) ?
                        LOG_IW'(log_tail_sum - (CNT_W+1)'(MAX_IN_FLIGHT)) :
                        LOG_IW'(log_tail_sum);
  assign q_tail_sum   = (FILL_W+1)'(q_head) + (FILL_W+1)'(q_fill);
  assign q_tail       = (q_tail_sum >= (FILL_W+1)'(QUEUE_DEPTH)) ?
                        Q_IW'(q_tail_sum - (FILL_W+1)'(QUEUE_DEPTH)) :
                        Q_IW'(q_tail_sum);
  assign q_full       = (q_fill >= FILL_W'(QUEUE_DEPTH));

  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts              = '0;
    sts.expire       = expire;
    sts.plan_release = (nrel != '0);
    sts.last_release = (rel_left == CNT_W'(1));
    sts.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate     <= MAX_RATE_RST;
      window_ticks <= WINDOW_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_RATE:     max_rate     <= cfg_data[RATE_W-1:0];
        REG_WINDOW_TICKS: window_ticks <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pending id memory: one write port, registered read at the queue head
  always_ff @(posedge clk) begin
    if (cmd.ingest && (in_action != ACTION_TICK) && !q_full) begin
      q_mem[q_tail] <= in_id;
    end
    rd_id <= q_mem[q_head];
  end

  always_ff @(posedge clk) begin
    if (cmd.release_id) begin
      log_mem[log_tail] <= now_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
      log_head  <= '0;
      log_count <= '0;
      q_head    <= '0;
      q_fill    <= '0;
      rel_left  <= '0;
      drop_flag <= 1'b0;
    end else begin
      if (cmd.ingest) begin
        drop_flag <= (in_action != ACTION_TICK) && q_full;
        if (in_action == ACTION_TICK) begin
          now_ticks <= now_ticks + TIME_WIDTH'(1);
        end else if (!q_full) begin
          q_fill <= q_fill + FILL_W'(1);
        end
      end
      if (cmd.pop) begin
        log_head  <= (log_head == LOG_LAST) ? '0 : log_head + LOG_IW'(1);
        log_count <= log_count - CNT_W'(1);
      end
      if (cmd.plan) begin
        rel_left <= nrel;
      end
      if (cmd.release_id) begin
        q_head    <= (q_head == Q_LAST) ? '0 : q_head + Q_IW'(1);
        q_fill    <= q_fill - FILL_W'(1);
        log_count <= log_count + CNT_W'(1);
        rel_left  <= rel_left - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      head_age <= (log_count == '0) ? '0 : age[WIN_W-1:0];
    end
    if (cmd.plan) begin
      fin_pending <= pend_after;
      fin_count   <= count_after;
      fin_wait    <= wait_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.release_id || cmd.empty_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.release_id || cmd.empty_result) begin
      out_has_release <= cmd.release_id;
      out_id          <= cmd.release_id ? rd_id : '0;
      out_last        <= cmd.empty_result || (rel_left == CNT_W'(1));
      out_pending     <= PEND_CNT_W'(fin_pending);
      out_in_flight   <= FLIGHT_CNT_W'(fin_count);
      out_wait        <= fin_wait;
      out_dropped     <= drop_flag;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sliding_window_rate_limiter_core.sv
// Top level of the sliding window log rate limiter.
// Joins swrl_ctrl and swrl_dp; uses swrl_pkg.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     action, request_id
//   out      out_valid / out_ready   has_release, released_id, last, pending_count,
//                                    in_flight_count, wait_ticks, dropped
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item is ingested when idle, expires aged-out log entries one at a time, captures
// the head age and plans, then releases each id through a read and a load step, or
// takes the no-release step. Read steps cover the registered pending id memory read.
// Reset clears counters and pointers at once; no clearing pass is needed.
// A stalled out channel holds the controller in its load or no-release step;
// cfg is always ready.
`default_nettype none

module sliding_window_rate_limiter_core #(
  parameter int MAX_IN_FLIGHT = 16,
  parameter int QUEUE_DEPTH   = 64,
  parameter int TIME_WIDTH    = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               action,
  input  wire logic [swrl_pkg::ID_W-1:0]          request_id,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    has_release,
  output logic [swrl_pkg::ID_W-1:0]               released_id,
  output logic                                    last,
  output logic [swrl_pkg::PEND_CNT_W-1:0]         pending_count,
  output logic [swrl_pkg::FLIGHT_CNT_W-1:0]       in_flight_count,
  output logic [swrl_pkg::WAIT_W-1:0]             wait_ticks,
  output logic                                    dropped,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [swrl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [swrl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import swrl_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  swrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swrl_dp #(
    .MAX_IN_FLIGHT (MAX_IN_FLIGHT),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_action       (action),
    .in_id           (request_id),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_has_release (has_release),
    .out_id          (released_id),
    .out_last        (last),
    .out_pending     (pending_count),
    .out_in_flight   (in_flight_count),
    .out_wait        (wait_ticks),
    .out_dropped     (dropped)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for sliding_window_rate_limiter_core: a directed table, then random phases of
// requests and ticks; results are checked against an in-bench window and backlog model,
// or against typed table rows. Depends on swrl_pkg and the core RTL.

module testbench;
  import swrl_pkg::*;

  localparam int MAX_IN_FLIGHT = 16;
  localparam int QUEUE_DEPTH   = 64;
  localparam int TIME_WIDTH    = 32;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 290;

  localparam logic ACTION_ENQUEUE = ~ACTION_TICK;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                    has_rel;
    logic [ID_W-1:0]         rel_id;
    logic                    is_last;
    logic [PEND_CNT_W-1:0]   pend_cnt;
    logic [FLIGHT_CNT_W-1:0] flight_cnt;
    logic [WAIT_W-1:0]       ticks_left;
    logic                    drop_flag;
  } outcome_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   act;
    logic [ID_W-1:0]        id;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   typed;
    outcome_t               want;
  } plan_row_t;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    action     = 1'b0;
  logic [ID_W-1:0]         request_id = '0;
  logic                    out_ready  = 1'b1;
  logic                    cfg_valid  = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;
  logic                    in_ready;
  logic                    out_valid;
  logic                    has_release;
  logic [ID_W-1:0]         released_id;
  logic                    last;
  logic [PEND_CNT_W-1:0]   pending_count;
  logic [FLIGHT_CNT_W-1:0] in_flight_count;
  logic [WAIT_W-1:0]       wait_ticks;
  logic                    dropped;
  logic                    cfg_ready;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] log_time [MAX_IN_FLIGHT];
  int                    log_head;
  int                    log_count;
  logic [ID_W-1:0]       backlog [QUEUE_DEPTH];
  int                    backlog_head;
  int                    backlog_fill;
  logic [RATE_W-1:0]     rate_cfg;
  logic [WIN_W-1:0]      window_cfg;

  outcome_t  due_results [$];
  outcome_t  head_due;
  plan_row_t directed_plan [$];
  int        mismatch_count = 0;
  int        stall_left = 0;
  bit        tx_idle_on;
  bit        rx_idle_on;

  sliding_window_rate_limiter_core #(
    .MAX_IN_FLIGHT(MAX_IN_FLIGHT),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TIME_WIDTH   (TIME_WIDTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .request_id     (request_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .has_release    (has_release),
    .released_id    (released_id),
    .last           (last),
    .pending_count  (pending_count),
    .in_flight_count(in_flight_count),
    .wait_ticks     (wait_ticks),
    .dropped        (dropped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic advance_limiter(input logic act, input logic [ID_W-1:0] id, input logic keep);
    logic [ID_W-1:0]       freed [$];
    logic [TIME_WIDTH-1:0] age;
    logic                  drop;
    int                    cap;
    int                    gap_left;
    int                    n;
    outcome_t              r;
    drop = 1'b0;
    gap_left = 0;
    if (act == ACTION_TICK) begin
      now_t = now_t + 1;
    end else if (backlog_fill >= QUEUE_DEPTH) begin
      drop = 1'b1;
    end else begin
      backlog[(backlog_head + backlog_fill) % QUEUE_DEPTH] = id;
      backlog_fill++;
    end
    while (log_count > 0) begin
      age = now_t - log_time[log_head];
      if (age <= window_cfg) break;
      log_head = (log_head + 1) % MAX_IN_FLIGHT;
      log_count--;
    end
    cap = (int'(rate_cfg) > MAX_IN_FLIGHT) ? MAX_IN_FLIGHT : int'(rate_cfg);
    while (backlog_fill > 0 && log_count < cap && freed.size() < MAX_IN_FLIGHT) begin
      freed = {freed, backlog[backlog_head]};
      backlog_head = (backlog_head + 1) % QUEUE_DEPTH;
      backlog_fill--;
      log_time[(log_head + log_count) % MAX_IN_FLIGHT] = now_t;
      log_count++;
    end
    if (backlog_fill > 0 && log_count > 0) begin
      age = now_t - log_time[log_head];
      if (age <= window_cfg) gap_left = 1 + int'(window_cfg) - int'(age);
    end
    n = (freed.size() > 0) ? freed.size() : 1;
    for (int k = 0; k < n; k++) begin
      r.has_rel    = freed.size() > 0;
      r.rel_id     = (freed.size() > 0) ? freed[k] : '0;
      r.is_last    = (k == n - 1);
      r.pend_cnt   = PEND_CNT_W'(backlog_fill);
      r.flight_cnt = FLIGHT_CNT_W'(log_count);
      r.ticks_left = WAIT_W'(gap_left);
      r.drop_flag  = drop;
      if (keep) due_results = {due_results, r};
    end
  endtask

  function automatic plan_row_t item_row(input logic act, input logic [ID_W-1:0] id);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.act  = act;
    row.id   = id;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic act, input logic [ID_W-1:0] id,
                                          input logic has, input logic [ID_W-1:0] rid,
                                          input int pend, input int flight, input int left);
    plan_row_t row;
    row                 = item_row(act, id);
    row.typed           = 1'b1;
    row.want.has_rel    = has;
    row.want.rel_id     = rid;
    row.want.is_last    = 1'b1;
    row.want.pend_cnt   = PEND_CNT_W'(pend);
    row.want.flight_cnt = FLIGHT_CNT_W'(flight);
    row.want.ticks_left = WAIT_W'(left);
    row.want.drop_flag  = 1'b0;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic void append_row(input plan_row_t row);
    directed_plan = {directed_plan, row};
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(input logic act, input logic [ID_W-1:0] id, input logic typed,
                           input outcome_t want);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    request_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_limiter(act, id, !typed);
    if (typed) due_results = {due_results, want};
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAX_RATE) rate_cfg = val[RATE_W-1:0];
    else if (idx == REG_WINDOW_TICKS) window_cfg = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic flood, input logic calm, input int count);
    logic [RATE_W-1:0]     rate;
    logic [CFG_DATA_W-1:0] rate_word;
    logic [WIN_W-1:0]      win;
    logic                  act;
    logic [ID_W-1:0]       id;
    int                    tick_pct;
    tx_idle_on = !calm && $urandom_range(0, 3) != 0;
    rx_idle_on <= !calm && $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 5))
      0: rate = '0;
      1: rate = RATE_W'(1);
      2: rate = RATE_W'(MAX_IN_FLIGHT);
      3: rate = '1;
      default: rate = RATE_W'($urandom_range(1, MAX_IN_FLIGHT));
    endcase
    if (flood) rate = '0;
    case ($urandom_range(0, 5))
      0: win = '0;
      1: win = '1;
      2: win = WIN_W'($urandom_range(13, 400));
      default: win = WIN_W'($urandom_range(1, 12));
    endcase
    rate_word = CFG_DATA_W'($urandom);
    rate_word[RATE_W-1:0] = rate;
    write_reg(REG_MAX_RATE, rate_word);
    write_reg(REG_WINDOW_TICKS, win);
    tick_pct = flood ? 0 : $urandom_range(20, 70);
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 99) < tick_pct) ? ACTION_TICK : ACTION_ENQUEUE;
      case ($urandom_range(0, 15))
        0: id = '0;
        1: id = '1;
        default: id = {$urandom, $urandom};
      endcase
      push_item(act, id, 1'b0, '0);
      if (!flood && $urandom_range(0, 59) == 0) drain();
    end
  endtask

  task automatic check_field(input string what, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected nothing actual id %0h last %0b",
                 $time, released_id, last);
      end else begin
        head_due = due_results.pop_front();
        check_field("has_release", ID_W'(head_due.has_rel), ID_W'(has_release));
        check_field("released_id", head_due.rel_id, released_id);
        check_field("last", ID_W'(head_due.is_last), ID_W'(last));
        check_field("pending_count", ID_W'(head_due.pend_cnt), ID_W'(pending_count));
        check_field("in_flight_count", ID_W'(head_due.flight_cnt), ID_W'(in_flight_count));
        check_field("wait_ticks", ID_W'(head_due.ticks_left), ID_W'(wait_ticks));
        check_field("dropped", ID_W'(head_due.drop_flag), ID_W'(dropped));
      end
    end
  end

  initial begin
    #12_000_000;
    $display("** sliding_window_rate_limiter_core: FAILED **");
    $finish;
  end

  initial begin
    int planned;
    int n;
    rate_cfg     = MAX_RATE_RST;
    window_cfg   = WINDOW_TICKS_RST;
    now_t        = '0;
    log_head     = 0;
    log_count    = 0;
    backlog_head = 0;
    backlog_fill = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   <= 1'b1;

    append_row(typed_row(ACTION_ENQUEUE, 64'h0, 1'b1, 64'h0, 0, 1, 0));
    append_row(typed_row(ACTION_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                         64'hFFFF_FFFF_FFFF_FFFF, 0, 2, 0));
    append_row(typed_row(ACTION_TICK, 64'h5555_AAAA_5555_AAAA, 1'b0, 64'h0,
                         0, 2, 0));
    append_row(cfg_row(REG_MAX_RATE, 16'h0000));
    append_row(cfg_row(REG_WINDOW_TICKS, 16'h0000));
    append_row(typed_row(ACTION_ENQUEUE, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 64'h0,
                         1, 0, 0));
    append_row(item_row(ACTION_ENQUEUE, 64'h0123_4567_89AB_CDEF));
    append_row(cfg_row(REG_SPARE_A, 16'hFFFF));
    append_row(cfg_row(REG_SPARE_B, 16'h5555));
    append_row(cfg_row(REG_MAX_RATE, 16'hFFFF));
    append_row(item_row(ACTION_TICK, 64'h0));
    append_row(cfg_row(REG_WINDOW_TICKS, 16'hFFFF));
    append_row(cfg_row(REG_MAX_RATE, 16'h0002));
    append_row(typed_row(ACTION_ENQUEUE, 64'h8000_0000_0000_0001, 1'b0, 64'h0,
                         1, 2, 65536));
    append_row(item_row(ACTION_TICK, 64'hFFFF_FFFF_FFFF_FFFF));
    append_row(cfg_row(REG_MAX_RATE, 16'h0001));
    append_row(item_row(ACTION_ENQUEUE, 64'h7FFF_FFFF_FFFF_FFFE));
    append_row(cfg_row(REG_WINDOW_TICKS, 16'h0001));
    append_row(item_row(ACTION_TICK, 64'h0));
    append_row(item_row(ACTION_TICK, 64'h0));
    append_row(cfg_row(REG_MAX_RATE, 16'h0010));
    append_row(cfg_row(REG_WINDOW_TICKS, 16'h0005));
    append_row(item_row(ACTION_TICK, 64'h0));
    append_row(item_row(ACTION_ENQUEUE, 64'hDEAD_BEEF_CAFE_F00D));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        push_item(directed_plan[i].act, directed_plan[i].id, directed_plan[i].typed,
                  directed_plan[i].want);
      end
    end

    run_phase(1'b1, 1'b0, 70);
    planned = 70;
    while (planned < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        run_phase(1'b1, 1'b0, 70);
        planned += 70;
      end else begin
        n = $urandom_range(15, 40);
        run_phase(1'b0, 1'b0, n);
        planned += n;
      end
    end
    run_phase(1'b0, 1'b1, 30);
    drain();

    if (mismatch_count == 0) begin
      $display("** sliding_window_rate_limiter_core: PASSED **");
    end else begin
      $display("** sliding_window_rate_limiter_core: FAILED **");
    end
    $finish;
  end

endmodule
